// ===== src/dsg_pkg.sv =====
// Package for the diamond/spiral gradient pixel block: field widths,
// register indexes, mode codes and the CORDIC angle table.
// No dependencies.
package dsg_pkg;

  localparam int CfgAddrBits = 5;

  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_END_X   = 3'd2,
    REG_END_Y   = 3'd3,
    REG_COLOR_S = 3'd4,
    REG_COLOR_E = 3'd5,
    REG_SHAPE   = 3'd6,
    REG_REPEAT  = 3'd7
  } reg_idx_t;

  localparam logic [1:0] RepPad     = 2'd0;
  localparam logic [1:0] RepRepeat  = 2'd1;
  localparam logic [1:0] RepReflect = 2'd2;

  localparam logic ShapeDiamond = 1'b0;
  localparam logic ShapeSpiral  = 1'b1;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } argb_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/dsg_if.sv =====
// Valid/ready channel interfaces for the gradient pixel block.
// Depends on nothing.
interface dsg_pix_if #(parameter int W = 13) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] pixel_x;
  logic [W-1:0] pixel_y;
  modport source (output valid, pixel_x, pixel_y, input ready);
  modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface dsg_color_if ();
  logic       valid;
  logic       ready;
  logic [7:0] alpha;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  modport source (output valid, alpha, red, green, blue, input ready);
  modport sink   (input valid, alpha, red, green, blue, output ready);
endinterface

// ===== src/dsg_cordic_stage.sv =====
// One vectoring CORDIC micro-rotation with its pipeline register.
// Depends on dsg_pkg.
module dsg_cordic_stage #(
  parameter int STEP = 0,
  parameter int XW   = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          a_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [31:0]          a_o
);
  import dsg_pkg::*;
  localparam int S = STEP % 32;
  localparam logic [4:0] SI = 5'(S);

  logic signed [XW-1:0] xs, ys;
  assign xs = x_i >>> S;
  assign ys = y_i >>> S;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_i > 0) begin
        x_o <= x_i + ys;
        y_o <= y_i - xs;
        a_o <= a_i + atan_turn(SI);
      end else begin
        x_o <= x_i - ys;
        y_o <= y_i + xs;
        a_o <= a_i - atan_turn(SI);
      end
    end
  end
endmodule

// ===== src/dsg_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Quotient saturates to 31 bits. Depends on nothing.
module dsg_divider #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [30:0]   quo_o
);
  logic [NW-1:0] rem_r [NW+1];
  logic [NW-1:0] q_r   [NW+1];
  logic [DW-1:0] d_r   [NW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      q_r[0]   <= num_i;
      d_r[0]   <= den_i;
    end
  end

  for (genvar i = 0; i < NW; i++) begin : g_st
    logic [NW:0] trial;
    assign trial = {rem_r[i], q_r[i][NW-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i+1] <= d_r[i];
        if (trial >= {{(NW+1-DW){1'b0}}, d_r[i]}) begin
          rem_r[i+1] <= NW'(trial - {{(NW+1-DW){1'b0}}, d_r[i]});
          q_r[i+1]   <= {q_r[i][NW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= NW'(trial);
          q_r[i+1]   <= {q_r[i][NW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = (|q_r[NW][NW-1:31]) ? {31{1'b1}} : q_r[NW][30:0];
endmodule

// ===== src/dsg_isqrt.sv =====
// Pipelined bit-by-bit integer square root, one result bit per stage.
// Depends on nothing.
module dsg_isqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] n_i,
  output logic [RW-1:0]   r_o
);
  logic [2*RW-1:0] n_r [RW+1];
  logic [RW+1:0]   rem_r [RW+1];
  logic [RW-1:0]   q_r [RW+1];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= n_i;
      rem_r[0] <= '0;
      q_r[0]   <= '0;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_st
    logic [RW+3:0] trial, sub;
    assign trial = {rem_r[i], n_r[i][2*RW-1 -: 2]};
    assign sub   = {2'b0, q_r[i], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i+1] <= {n_r[i][2*RW-3:0], 2'b00};
        if (trial >= sub) begin
          rem_r[i+1] <= (RW+2)'(trial - sub);
          q_r[i+1]   <= {q_r[i][RW-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= (RW+2)'(trial);
          q_r[i+1]   <= {q_r[i][RW-2:0], 1'b0};
        end
      end
    end
  end
  assign r_o = q_r[RW];
endmodule

// ===== src/diamond_spiral_gradient_pixel_top.sv =====
// Diamond / spiral gradient pixel generator, fully pipelined.
// Throughput: one pixel per clock; a color beat that the sink does not take stalls the pipe.
// Depth: 3 + (SQW+1) + (41+FRAC_BITS) + 3 = 96 register stages by default. The square root
// and the restoring divider (one quotient bit per stage) set nearly all of it.
// Reset (rst_n synchronous, low) clears all valid bits and loads the register reset values.
module diamond_spiral_gradient_pixel_top #(
  parameter int COORD_BITS   = 13,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  dsg_pix_if.sink                       in_ch,
  dsg_color_if.source                   out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dsg_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import dsg_pkg::*;

  // Arithmetic widths. Coordinates differences stay within 17 bits signed.
  localparam int CW  = 17;          // p, d components
  localparam int PW  = 36;          // products and squares
  localparam int NUMW = 33 + FRAC_BITS + 4; // diamond numerator after shift
  localparam int XW  = 30;          // CORDIC datapath (value*256 plus growth)
  localparam int SQW = 32;          // sqrt result width (sqrt of a 64-bit radicand)
  localparam int DIVW = 40 + FRAC_BITS; // dist numerator width
  localparam int DW  = NUMW > DIVW ? NUMW : DIVW;
  // Stage counts of the three parallel branches; the quotient leaves the divider
  // at stage DEPTH + 1, and the angle and side data are delayed to meet it there.
  localparam int LEN_DIV  = DW + 1;
  localparam int LEN_SQ   = SQW + 1;
  localparam int DEPTH    = 2 + LEN_SQ + LEN_DIV;
  localparam int TOT      = DEPTH + 4;

  // ---------------- configuration registers ----------------
  logic signed [14:0] start_x_r, start_y_r, end_x_r, end_y_r;
  logic [31:0] color_start_r, color_end_r;
  logic shape_mode_r;
  logic [1:0] repeat_mode_r;
  logic cfg_we;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0; start_y_r <= '0; end_x_r <= '0; end_y_r <= '0;
      color_start_r <= 32'hFF00_0000;
      color_end_r <= 32'hFFFF_FFFF;
      shape_mode_r <= ShapeDiamond;
      repeat_mode_r <= RepPad;
    end else if (cfg_we && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_idx)
        REG_START_X: start_x_r <= cfg_pwdata[14:0];
        REG_START_Y: start_y_r <= cfg_pwdata[14:0];
        REG_END_X:   end_x_r <= cfg_pwdata[14:0];
        REG_END_Y:   end_y_r <= cfg_pwdata[14:0];
        REG_COLOR_S: color_start_r <= cfg_pwdata;
        REG_COLOR_E: color_end_r <= cfg_pwdata;
        REG_SHAPE:   shape_mode_r <= cfg_pwdata[0];
        REG_REPEAT:  repeat_mode_r <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_START_X: cfg_prdata = 32'(unsigned'(start_x_r));
      REG_START_Y: cfg_prdata = 32'(unsigned'(start_y_r));
      REG_END_X:   cfg_prdata = 32'(unsigned'(end_x_r));
      REG_END_Y:   cfg_prdata = 32'(unsigned'(end_y_r));
      REG_COLOR_S: cfg_prdata = color_start_r;
      REG_COLOR_E: cfg_prdata = color_end_r;
      REG_SHAPE:   cfg_prdata = {31'b0, shape_mode_r};
      REG_REPEAT:  cfg_prdata = {30'b0, repeat_mode_r};
      default:     cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  // The whole pipe advances together; it stalls only when the output register
  // holds a beat that the sink does not take. The output register itself is
  // the last stage, so a full pipe still accepts while the result drains.
  logic adv;
  logic [TOT-1:0] vld_r;
  assign adv = !vld_r[TOT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[TOT-2:0], in_ch.valid};
  end

  // Stage 1: differences.
  logic signed [CW-1:0] px_r, py_r, dx_r, dy_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= CW'($signed({1'b0, in_ch.pixel_x[COORD_BITS-1:0]})) - CW'(start_x_r);
      py_r <= CW'($signed({1'b0, in_ch.pixel_y[COORD_BITS-1:0]})) - CW'(start_y_r);
      dx_r <= CW'(end_x_r) - CW'(start_x_r);
      dy_r <= CW'(end_y_r) - CW'(start_y_r);
    end
  end

  // Stage 2: products (one multiplier each, registered).
  logic signed [PW-1:0] pxdx_r, pydy_r, pydx_r, pxdy_r, pxpx_r, pypy_r, dxdx_r, dydy_r;
  logic signed [CW-1:0] px2_r, py2_r, dx2_r, dy2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      pxdx_r <= PW'(px_r * dx_r); pydy_r <= PW'(py_r * dy_r);
      pydx_r <= PW'(py_r * dx_r); pxdy_r <= PW'(px_r * dy_r);
      pxpx_r <= PW'(px_r * px_r); pypy_r <= PW'(py_r * py_r);
      dxdx_r <= PW'(dx_r * dx_r); dydy_r <= PW'(dy_r * dy_r);
      px2_r <= px_r; py2_r <= py_r; dx2_r <= dx_r; dy2_r <= dy_r;
    end
  end

  // Stage 3: sums and magnitudes.
  logic signed [PW:0] dot_w, crs_w;
  logic [PW:0] num3_r;
  logic [PW-1:0] p2_r, d2_r;
  logic signed [CW-1:0] px3_r, py3_r, dx3_r, dy3_r;
  assign dot_w = (PW+1)'(pxdx_r) + (PW+1)'(pydy_r);
  assign crs_w = (PW+1)'(pydx_r) - (PW+1)'(pxdy_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      num3_r <= (dot_w < 0 ? (PW+1)'(-dot_w) : (PW+1)'(dot_w))
              + (crs_w < 0 ? (PW+1)'(-crs_w) : (PW+1)'(crs_w));
      p2_r <= PW'(pxpx_r + pypy_r);
      d2_r <= PW'(dxdx_r + dydy_r);
      px3_r <= px2_r; py3_r <= py2_r; dx3_r <= dx2_r; dy3_r <= dy2_r;
    end
  end

  // Diamond quotient inputs: delayed by the square root latency so both
  // branches meet at the divider input.
  logic [PW:0] numd_r [LEN_SQ];
  logic [PW-1:0] d2d_r [LEN_SQ];
  always_ff @(posedge clk) begin
    if (adv) begin
      numd_r[0] <= num3_r; d2d_r[0] <= d2_r;
      for (int i = 0; i < LEN_SQ - 1; i++) begin
        numd_r[i+1] <= numd_r[i]; d2d_r[i+1] <= d2d_r[i];
      end
    end
  end

  // Square roots of |p|^2*2^32 and |d|^2*2^32.
  logic [SQW-1:0] rp_w, rd_w;
  dsg_isqrt #(.RW(SQW)) u_sqp (.clk, .en(adv),
    .n_i({p2_r[SQW-1:0], 32'b0}), .r_o(rp_w));
  dsg_isqrt #(.RW(SQW)) u_sqd (.clk, .en(adv),
    .n_i({d2_r[SQW-1:0], 32'b0}), .r_o(rd_w));

  // Shared divider: selects diamond or spiral distance by mode.
  logic [DW-1:0] dnum_w;
  logic [SQW+1:0] dden_w;
  logic [30:0] quo_w;
  assign dnum_w = shape_mode_r == ShapeDiamond
                ? DW'({numd_r[LEN_SQ-1], FRAC_BITS'(0)})
                : DW'({rp_w, FRAC_BITS'(0)});
  assign dden_w = shape_mode_r == ShapeDiamond
                ? (SQW+2)'(d2d_r[LEN_SQ-1]) : (SQW+2)'(rd_w);
  dsg_divider #(.NW(DW), .DW(SQW+2)) u_div (.clk, .en(adv),
    .num_i(dnum_w), .den_i(dden_w), .quo_o(quo_w));

  // CORDIC on p and d, starting at stage 3, padded to the same depth.
  localparam int CD = DEPTH - CORDIC_STEPS - 3;
  logic signed [XW-1:0] xp0, yp0, xd0, yd0;
  logic [31:0] ap0, ad0;
  logic zp0, zd0;
  always_comb begin
    xp0 = XW'(px3_r) <<< 8; yp0 = XW'(py3_r) <<< 8; ap0 = '0;
    if (px3_r < 0) begin xp0 = -xp0; yp0 = -yp0; ap0 = 32'h8000_0000; end
    xd0 = XW'(dx3_r) <<< 8; yd0 = XW'(dy3_r) <<< 8; ad0 = '0;
    if (dx3_r < 0) begin xd0 = -xd0; yd0 = -yd0; ad0 = 32'h8000_0000; end
    zp0 = px3_r == 0 && py3_r == 0;
    zd0 = dx3_r == 0 && dy3_r == 0;
  end

  logic signed [XW-1:0] xp [CORDIC_STEPS+1], yp [CORDIC_STEPS+1];
  logic signed [XW-1:0] xd [CORDIC_STEPS+1], yd [CORDIC_STEPS+1];
  logic [31:0] ap [CORDIC_STEPS+1], ad [CORDIC_STEPS+1];
  assign xp[0] = xp0; assign yp[0] = yp0; assign ap[0] = ap0;
  assign xd[0] = xd0; assign yd[0] = yd0; assign ad[0] = ad0;
  for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_cor
    dsg_cordic_stage #(.STEP(s), .XW(XW)) u_p (.clk, .en(adv),
      .x_i(xp[s]), .y_i(yp[s]), .a_i(ap[s]), .x_o(xp[s+1]), .y_o(yp[s+1]), .a_o(ap[s+1]));
    dsg_cordic_stage #(.STEP(s), .XW(XW)) u_d (.clk, .en(adv),
      .x_i(xd[s]), .y_i(yd[s]), .a_i(ad[s]), .x_o(xd[s+1]), .y_o(yd[s+1]), .a_o(ad[s+1]));
  end
  logic [CORDIC_STEPS-1:0] zp_r, zd_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      zp_r <= {zp_r[CORDIC_STEPS-2:0], zp0};
      zd_r <= {zd_r[CORDIC_STEPS-2:0], zd0};
    end
  end

  // Angle difference registered, then delayed to the join.
  logic signed [33:0] da_w;
  logic signed [33:0] da_r [CD+1];
  function automatic logic signed [33:0] sgn_ang(input logic [31:0] a, input logic z);
    logic signed [33:0] v;
    v = z ? 34'sd0 : (a > 32'h8000_0000 ? $signed({2'b0, a}) - 34'sh1_0000_0000
                                         : $signed({2'b0, a}));
    return v;
  endfunction
  assign da_w = sgn_ang(ap[CORDIC_STEPS], zp_r[CORDIC_STEPS-1])
              - sgn_ang(ad[CORDIC_STEPS], zd_r[CORDIC_STEPS-1]);
  always_ff @(posedge clk) begin
    if (adv) begin
      da_r[0] <= da_w;
      for (int i = 0; i < CD; i++) da_r[i+1] <= da_r[i];
    end
  end

  // Zero-length side data travels beside the value.
  logic dz_r [DEPTH-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      dz_r[0] <= (dx2_r == 0) && (dy2_r == 0);
      for (int i = 0; i < DEPTH - 2; i++) dz_r[i+1] <= dz_r[i];
    end
  end

  // Join: t = quotient (+ angle term in spiral mode), saturated.
  logic signed [33:0] t_w;
  logic signed [31:0] t_r;
  logic dz_j_r;
  assign t_w = shape_mode_r == ShapeDiamond ? 34'($signed({1'b0, quo_w}))
             : 34'($signed({1'b0, quo_w})) + (da_r[CD] >>> (32 - FRAC_BITS));
  always_ff @(posedge clk) begin
    if (adv) begin
      t_r <= t_w > 34'sh0_7FFF_FFFF ? 32'sh7FFF_FFFF
           : (t_w < -34'sh0_8000_0000 ? 32'sh8000_0000 : 32'(t_w));
      dz_j_r <= dz_r[DEPTH-2];
    end
  end

  // Fold to [0, ONE].
  localparam logic signed [32:0] ONE = 33'sd1 <<< FRAC_BITS;
  logic signed [32:0] at_w;
  logic [FRAC_BITS:0] f_w, tf_w;
  logic [FRAC_BITS:0] tf_r;
  logic dz_f_r;
  assign at_w = t_r < 0 ? -33'(t_r) : 33'(t_r);
  assign f_w = at_w[FRAC_BITS:0];
  always_comb begin
    case (repeat_mode_r)
      RepRepeat:  tf_w = {1'b0, t_r[FRAC_BITS-1:0]};
      RepReflect: tf_w = f_w <= ONE[FRAC_BITS:0] ? f_w : (FRAC_BITS+1)'(2 * ONE - 33'(f_w));
      default:    tf_w = t_r < 0 ? '0 : (33'(t_r) > ONE ? ONE[FRAC_BITS:0] : t_r[FRAC_BITS:0]);
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      tf_r <= tf_w;
      dz_f_r <= dz_j_r;
    end
  end

  // Blend: four small multipliers, then floor shift.
  argb_t c0, c1, res_w;
  assign c0 = color_start_r;
  assign c1 = color_end_r;
  function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                     input logic [FRAC_BITS:0] f);
    logic signed [FRAC_BITS+11:0] n;
    n = ($signed({4'b0, a}) <<< FRAC_BITS)
      + ($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, f});
    return n < 0 ? 8'd0 : n[FRAC_BITS +: 8];
  endfunction
  assign res_w = dz_f_r ? c0 : {mix(c0.alpha, c1.alpha, tf_r),
                                mix(c0.red,   c1.red,   tf_r),
                                mix(c0.green, c1.green, tf_r),
                                mix(c0.blue,  c1.blue,  tf_r)};
  argb_t out_r;
  always_ff @(posedge clk) if (adv) out_r <= res_w;

  assign out_ch.valid = vld_r[TOT-1];
  assign out_ch.alpha = out_r.alpha;
  assign out_ch.red   = out_r.red;
  assign out_ch.green = out_r.green;
  assign out_ch.blue  = out_r.blue;
endmodule

// ===== tb/sv/tb_diamond_spiral_gradient_pixel_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the diamond/spiral gradient pixel block.
// Depends on dsg_pkg, the dsg_pix_if/dsg_color_if interfaces and the top level.
module tb_diamond_spiral_gradient_pixel_top;
  import dsg_pkg::*;

  localparam int       ONE       = 1 << 16;
  localparam int       CYC_LIMIT = 400000;
  localparam int       HOLD_LEN  = 400;
  localparam int       TAIL_WAIT = 200;

  // Repeat mode code that the block does not define; it must act as pad.
  localparam logic [1:0] RepSpare = 2'd3;

  // Arctangent of 2^-i in turns scaled by 2^32, used by the angle predictor.
  localparam longint ATAN_TURNS [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
    83443, 41722, 20861
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CfgAddrBits-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  dsg_pix_if #(.W(13)) pix_bus ();
  dsg_color_if         color_bus ();

  diamond_spiral_gradient_pixel_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (pix_bus),
    .out_ch     (color_bus),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the gradient registers, kept in step with every write.
  longint    sh_start_x, sh_start_y, sh_end_x, sh_end_y;
  bit [31:0] sh_color_s, sh_color_e;
  bit        sh_shape;
  bit [1:0]  sh_repeat;

  argb_t     color_q [$];       // expected pixel colors, oldest first
  int        fail_cnt = 0;
  int        cycle_cnt = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  bit        hold_req = 1'b0;

  // A directed row may carry a typed-in color; the monitor uses it instead
  // of the predictor while that beat is on the input.
  bit        typed_en = 1'b0;
  argb_t     typed_color;

  function automatic longint sat_q16(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // CORDIC vectoring angle in turns * 2^32, read as signed in (-2^31, 2^31].
  function automatic longint vector_turns(longint x, longint y);
    bit [31:0] ang;
    longint xs, ys;
    ang = '0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + ATAN_TURNS[i][31:0];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - ATAN_TURNS[i][31:0];
      end
    end
    if (ang > 32'h8000_0000) return longint'(ang) - 64'sh1_0000_0000;
    return longint'(ang);
  endfunction

  function automatic argb_t gradient_color(logic [12:0] x, logic [12:0] y);
    longint px, py, dx, dy, d2, t, tf, num, radial, da, c0, c1;
    longint unsigned rp, rd;
    argb_t res;
    bit [31:0] packed_c;
    px = longint'(x) - sh_start_x;
    py = longint'(y) - sh_start_y;
    dx = sh_end_x - sh_start_x;
    dy = sh_end_y - sh_start_y;
    d2 = dx * dx + dy * dy;
    if (d2 == 0) return argb_t'(sh_color_s);
    if (sh_shape == ShapeDiamond) begin
      num = px * dx + py * dy;
      if (num < 0) num = -num;
      da = py * dx - px * dy;
      if (da < 0) da = -da;
      t = sat_q16(((num + da) <<< 16) / d2);
    end else begin
      rp = int_sqrt(longint'(unsigned'(px * px + py * py)) << 32);
      rd = int_sqrt(longint'(unsigned'(d2)) << 32);
      radial = sat_q16(longint'((rp << 16) / rd));
      da = vector_turns(px, py) - vector_turns(dx, dy);
      t = sat_q16(radial + (da >>> 16));
    end
    case (sh_repeat)
      RepRepeat: tf = t & (ONE - 1);
      RepReflect: begin
        tf = ((t < 0) ? -t : t) % (2 * ONE);
        if (tf > ONE) tf = 2 * ONE - tf;
      end
      default: tf = (t < 0) ? 0 : ((t > ONE) ? ONE : t);
    endcase
    for (int k = 0; k < 4; k++) begin
      c0 = longint'(sh_color_s[24 - 8 * k +: 8]);
      c1 = longint'(sh_color_e[24 - 8 * k +: 8]);
      num = c0 * ONE + (c1 - c0) * tf;
      if (num < 0) num = 0;
      packed_c[24 - 8 * k +: 8] = num[23:16];
    end
    res = argb_t'(packed_c);
    return res;
  endfunction

  // Monitor: predicts on every accepted pixel beat and checks every color beat.
  always @(posedge clk) begin
    argb_t got, want;
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && pix_bus.valid && pix_bus.ready) begin
      if (typed_en) color_q.push_back(typed_color);
      else color_q.push_back(gradient_color(pix_bus.pixel_x, pix_bus.pixel_y));
    end
    if (rst_n && color_bus.valid && color_bus.ready) begin
      got = '{color_bus.alpha, color_bus.red, color_bus.green, color_bus.blue};
      if (color_q.size() == 0) begin
        $error("color beat %h with no pixel outstanding", got);
        fail_cnt <= fail_cnt + 1;
      end else begin
        want = color_q.pop_front();
        if (got.alpha !== want.alpha) $error("alpha: expected %h, got %h", want.alpha, got.alpha);
        if (got.red !== want.red) $error("red: expected %h, got %h", want.red, got.red);
        if (got.green !== want.green) $error("green: expected %h, got %h", want.green, got.green);
        if (got.blue !== want.blue) $error("blue: expected %h, got %h", want.blue, got.blue);
        if (got !== want) fail_cnt <= fail_cnt + 1;
      end
    end
    if (cycle_cnt > CYC_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here so that the
  // pipeline fills and back-pressures the pixel input.
  always @(negedge clk) begin
    int hold_cnt;
    bit hold_done;
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_LEN;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      color_bus.ready <= 1'b0;
    end else begin
      color_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial color_bus.ready = 1'b0;

  // Register write over the config port; the caller guarantees the block is idle.
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CfgAddrBits'(idx) << 2;
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      REG_START_X: sh_start_x = longint'(signed'(val[14:0]));
      REG_START_Y: sh_start_y = longint'(signed'(val[14:0]));
      REG_END_X:   sh_end_x = longint'(signed'(val[14:0]));
      REG_END_Y:   sh_end_y = longint'(signed'(val[14:0]));
      REG_COLOR_S: sh_color_s = val;
      REG_COLOR_E: sh_color_e = val;
      REG_SHAPE:   sh_shape = val[0];
      REG_REPEAT:  sh_repeat = val[1:0];
      default: ;
    endcase
  endtask

  // Offers one pixel beat; starts and ends at a falling edge and leaves valid
  // high so that back-to-back beats never toggle it within one time step.
  task automatic send_pixel(logic [12:0] x, logic [12:0] y, bit typed, argb_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_bus.valid = 1'b0;
      @(negedge clk);
    end
    pix_bus.valid = 1'b1;
    pix_bus.pixel_x = x;
    pix_bus.pixel_y = y;
    typed_en = typed;
    typed_color = want;
    do @(posedge clk); while (!pix_bus.ready);
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every expected color has come back.
  task automatic drain();
    pix_bus.valid = 1'b0;
    typed_en = 1'b0;
    while (color_q.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [31:0] val;
    logic [12:0] x, y;
    bit          typed;
    argb_t       want;
  } plan_row_t;

  plan_row_t plan [$];

  task automatic plan_cfg(reg_idx_t idx, logic [31:0] val);
    plan.push_back('{1'b1, idx, val, 13'd0, 13'd0, 1'b0, argb_t'(32'd0)});
  endtask

  task automatic plan_pix(int x, int y, bit typed = 1'b0, logic [31:0] want = 0);
    plan.push_back('{1'b0, REG_START_X, 32'd0, 13'(x), 13'(y), typed, argb_t'(want)});
  endtask

  task automatic random_setup();
    int kind;
    logic [14:0] c [4];
    kind = $urandom_range(7);
    for (int i = 0; i < 4; i++) begin
      case (kind)
        0: c[i] = $urandom_range(1) ? 15'h3FFF : 15'h4000;   // extremes
        1, 2: c[i] = 15'($urandom_range(8191));               // inside the raster
        default: c[i] = 15'($urandom_range(32767));
      endcase
    end
    if (kind == 7) begin                                       // start equals end
      c[2] = c[0];
      c[3] = c[1];
    end
    write_reg(REG_START_X, 32'(c[0]));
    write_reg(REG_START_Y, 32'(c[1]));
    write_reg(REG_END_X, 32'(c[2]));
    write_reg(REG_END_Y, 32'(c[3]));
    write_reg(REG_COLOR_S, $urandom());
    write_reg(REG_COLOR_E, $urandom_range(3) == 0 ? 32'hFFFF_FFFF : $urandom());
    write_reg(REG_SHAPE, 32'($urandom_range(1)));
    write_reg(REG_REPEAT, 32'($urandom_range(3)));
  endtask

  initial begin
    pix_bus.valid = 1'b0;
    pix_bus.pixel_x = '0;
    pix_bus.pixel_y = '0;
    sh_start_x = 0; sh_start_y = 0; sh_end_x = 0; sh_end_y = 0;
    sh_color_s = 32'hFF00_0000;
    sh_color_e = 32'hFFFF_FFFF;
    sh_shape = ShapeDiamond;
    sh_repeat = RepPad;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // After reset start equals end, so every pixel takes the start color.
    plan_pix(0, 0, 1, 32'hFF00_0000);
    plan_pix(8191, 8191, 1, 32'hFF00_0000);
    // Horizontal gradient, 200 pixels long, diamond shape, pad.
    plan_cfg(REG_START_X, 100);
    plan_cfg(REG_START_Y, 200);
    plan_cfg(REG_END_X, 300);
    plan_cfg(REG_END_Y, 200);
    plan_cfg(REG_COLOR_S, 32'h1020_4080);
    plan_cfg(REG_COLOR_E, 32'hF0E0_C0A0);
    plan_pix(100, 200, 1, 32'h1020_4080);
    plan_pix(300, 200, 1, 32'hF0E0_C0A0);
    plan_pix(0, 0);
    plan_pix(8191, 0);
    plan_pix(0, 8191);
    plan_cfg(REG_REPEAT, RepRepeat);
    plan_pix(400, 200);
    plan_pix(250, 300);
    plan_cfg(REG_REPEAT, RepReflect);
    plan_pix(400, 200);
    plan_pix(350, 200);
    plan_pix(20, 150);
    plan_cfg(REG_REPEAT, RepSpare);           // unused code behaves as pad
    plan_pix(500, 200);
    plan_cfg(REG_SHAPE, ShapeSpiral);
    plan_cfg(REG_REPEAT, RepPad);
    plan_pix(100, 200);                       // pixel on the anchor: zero vector
    plan_pix(300, 200);
    plan_pix(100, 400);
    plan_pix(0, 200);
    plan_cfg(REG_REPEAT, RepReflect);
    plan_pix(8191, 8191);
    // Tiny gradient vector far from the raster: t saturates, pad clamps to one.
    plan_cfg(REG_SHAPE, ShapeDiamond);
    plan_cfg(REG_REPEAT, RepPad);
    plan_cfg(REG_START_X, 32'h4000);
    plan_cfg(REG_START_Y, 32'h4000);
    plan_cfg(REG_END_X, 32'h4001);
    plan_cfg(REG_END_Y, 32'h4000);
    plan_pix(8191, 8191, 1, 32'hF0E0_C0A0);
    plan_cfg(REG_REPEAT, RepReflect);
    plan_pix(8191, 8191);
    plan_cfg(REG_END_X, 32'h3FFF);
    plan_cfg(REG_END_Y, 32'h3FFF);
    plan_cfg(REG_SHAPE, ShapeSpiral);
    plan_pix(0, 8191);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_pixel(plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
      end
    end

    // Random part in three idling phases, ten register settings in each. The
    // block that runs during the long receiver hold-off offers more beats than
    // the pipeline holds, so the input is stalled for a while.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 31 : ((ph == 1) ? 72 : 0);
      recv_idle_pct = (ph == 0) ? 72 : ((ph == 1) ? 31 : 0);
      for (int blk = 0; blk < 10; blk++) begin
        drain();
        random_setup();
        if (ph == 0 && blk == 1) hold_req = 1'b1;
        for (int n = 0; n < ((ph == 0 && blk == 1) ? 150 : 47); n++) begin
          if ($urandom_range(3) == 0 && sh_start_x >= 0 && sh_start_x < 8100
              && sh_start_y >= 0 && sh_start_y < 8100) begin
            send_pixel(13'(sh_start_x + $urandom_range(80)),
                       13'(sh_start_y + $urandom_range(80)), 1'b0, argb_t'(32'd0));
          end else begin
            send_pixel(13'($urandom()), 13'($urandom()), 1'b0, argb_t'(32'd0));
          end
        end
      end
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
